// ----- src/assert_macros.svh -----
// Assertion macros used by the RTL of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on each rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on each rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/ptb_pkg.sv -----
// Package with types and constants of the particle time boundary core.
`default_nettype none

package ptb_pkg;

  localparam int DATA_W     = 32;
  localparam int DUR_W      = DATA_W - 1;
  localparam int MODE_W     = 2;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DATA_W / DIV_BITS;
  localparam int NUM_STAGES = DIV_STAGES + 4;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [MODE_W-1:0] {
    BC_OPEN     = 2'd0,
    BC_PERIODIC = 2'd1,
    BC_ABSORB   = 2'd2,
    BC_REFLECT  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 1'b0,
    CFG_DURATION = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] pt;
    logic              neg;
    logic [DATA_W-1:0] mag;
    logic [DUR_W-1:0]  rem;
    logic              above;
    logic              below;
    logic              lost;
    logic [DATA_W-1:0] tout;
    logic [DATA_W-1:0] ptout;
  } pipe_t;

endpackage

`default_nettype wire

// ----- src/particle_time_boundary_core.sv -----
// Top level of the particle time boundary core.
// Usage:
//   Slave stream (s_tvalid, s_tready, s_tdata) carries one particle per
//   transaction: time in bits 31:0, energy deviation in bits 63:32, both
//   signed Q16.16. Master stream (m_tvalid, m_tready, m_tdata, m_tuser)
//   returns one result per particle in the same order, same packing,
//   with the lost flag in m_tuser.
//   Configuration: cfg_we with cfg_index 0 writes the boundary mode,
//   index 1 writes the bucket duration. Write only while no particle is
//   in flight.
//   Pipeline: twelve register stages, the entry stage loaded at the
//   accepting edge: entry, the restoring remainder unit (4 bits per
//   stage over 8 stages), sign fix, wrap and output stages. m_tvalid
//   is the valid flag of the output stage.
//   Throughput: one particle per cycle while m_tready does not stall.
//   Reset: rst (synchronous) empties the pipeline and clears both
//   registers (open mode, zero duration).
//   Stall: with m_tready low the last stage holds; earlier stages keep
//   advancing into empty slots, and s_tready falls only once every
//   stage holds a particle.
`default_nettype none
`include "assert_macros.svh"

module particle_time_boundary_core
  import ptb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [2*DATA_W-1:0]  s_tdata,   // time_in, energy_in
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [2*DATA_W-1:0]  m_tdata,   // time_out, energy_out
  output logic      [0:0]           m_tuser,   // lost
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wdata
);

  localparam int LAST = NUM_STAGES - 1;
  localparam int EW   = DATA_W + 2;

  mode_t            bc_mode;
  logic [DUR_W-1:0] dur;
  logic [DUR_W-1:0] half;

  pipe_t p   [NUM_STAGES];
  logic  vld [NUM_STAGES];
  logic [NUM_STAGES:0] en;

  function automatic logic [DATA_W-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = EW'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - EW'(1);
    if (v > hi) begin
      sat = hi[DATA_W-1:0];
    end else if (v < lo) begin
      sat = lo[DATA_W-1:0];
    end else begin
      sat = v[DATA_W-1:0];
    end
  endfunction

  assign half = {1'b0, dur[DUR_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      bc_mode <= BC_OPEN;
      dur     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:     bc_mode <= mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_DURATION: dur     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NUM_STAGES] = m_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    pipe_t nx;
    logic  vin;

    if (k == 0) begin : g_entry
      logic [DATA_W-1:0] t_in;
      assign t_in = s_tdata[DATA_W-1:0];
      assign vin  = s_tvalid;
      always_comb begin
        nx       = '0;
        nx.mode  = bc_mode;
        nx.t     = t_in;
        nx.pt    = s_tdata[2*DATA_W-1:DATA_W];
        nx.neg   = t_in[DATA_W-1];
        nx.mag   = t_in[DATA_W-1] ? (~t_in + DATA_W'(1)) : t_in;
      end
    end else if (k <= DIV_STAGES) begin : g_div
      logic [DUR_W-1:0] rem_new;
      assign vin = vld[k-1];
      ptb_rem_step u_step (
        .rem_in  (p[k-1].rem),
        .bits    (p[k-1].mag[DATA_W-1 -: DIV_BITS]),
        .divisor (dur),
        .rem_out (rem_new)
      );
      always_comb begin
        nx     = p[k-1];
        nx.rem = rem_new;
        nx.mag = p[k-1].mag << DIV_BITS;
      end
    end else if (k == DIV_STAGES + 1) begin : g_fix
      logic signed [DATA_W-1:0] ts;
      logic signed [DATA_W-1:0] hs;
      assign vin = vld[k-1];
      assign ts  = $signed(p[k-1].t);
      assign hs  = $signed({1'b0, half});
      always_comb begin
        nx       = p[k-1];
        nx.rem   = (p[k-1].neg && p[k-1].rem != '0) ? (dur - p[k-1].rem) : p[k-1].rem;
        nx.above = ts > hs;
        nx.below = ts < -hs;
        nx.lost  = (p[k-1].mode == BC_ABSORB) && !(ts < hs && ts > -hs);
      end
    end else if (k == DIV_STAGES + 2) begin : g_wrap
      logic [DUR_W:0] sum;
      assign vin = vld[k-1];
      always_comb begin
        nx  = p[k-1];
        sum = {1'b0, p[k-1].rem} + {1'b0, half};
        if (sum >= {1'b0, dur}) begin
          sum = sum - {1'b0, dur};
        end
        nx.rem = sum[DUR_W-1:0];
      end
    end else begin : g_out
      logic signed [EW-1:0] te;
      logic signed [EW-1:0] pe;
      logic signed [EW-1:0] de;
      logic signed [EW-1:0] he;
      logic signed [EW-1:0] re;
      logic signed [EW-1:0] rt;
      logic signed [EW-1:0] rp;
      assign vin = vld[k-1];
      assign te  = {{2{p[k-1].t[DATA_W-1]}}, p[k-1].t};
      assign pe  = {{2{p[k-1].pt[DATA_W-1]}}, p[k-1].pt};
      assign de  = {3'b0, dur};
      assign he  = {3'b0, half};
      assign re  = {3'b0, p[k-1].rem};
      always_comb begin
        rt = te;
        rp = pe;
        case (p[k-1].mode)
          BC_PERIODIC: begin
            if (dur != '0) begin
              rt = re - he;
            end
          end
          BC_REFLECT: begin
            if (p[k-1].above) begin
              rt = de - te;
              rp = -pe;
            end else if (p[k-1].below) begin
              rt = -de - te;
              rp = -pe;
            end
          end
          default: ;
        endcase
        nx       = p[k-1];
        nx.tout  = sat(rt);
        nx.ptout = sat(rp);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        p[k] <= nx;
      end
    end
  end

  assign m_tvalid = vld[LAST];
  assign m_tdata  = {p[LAST].ptout, p[LAST].tout};
  assign m_tuser  = p[LAST].lost;

  `ASSERT_CLK(a_lost_absorb_only, m_tvalid && m_tuser[0] |-> p[LAST].mode == BC_ABSORB, "lost flag outside absorbing mode")
  `ASSERT_CLK(a_stall_only_full, !s_tready |-> vld[LAST] && !m_tready, "input stalled without output stall")
  `ASSERT_CLK(a_open_passes, m_tvalid && p[LAST].mode == BC_OPEN |-> p[LAST].tout == p[LAST].t && p[LAST].ptout == p[LAST].pt, "open mode altered particle")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

endmodule

`default_nettype wire

// ----- src/ptb_rem_step.sv -----
// Restoring remainder step over a few dividend bits.
`default_nettype none

module ptb_rem_step
  import ptb_pkg::*;
(
  input  wire logic [DUR_W-1:0]    rem_in,
  input  wire logic [DIV_BITS-1:0] bits,
  input  wire logic [DUR_W-1:0]    divisor,
  output logic      [DUR_W-1:0]    rem_out
);

  logic [DUR_W:0]   acc;
  logic [DUR_W-1:0] r;

  always_comb begin
    r   = rem_in;
    acc = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      acc = {r, bits[DIV_BITS-1-i]};
      if (acc >= {1'b0, divisor}) begin
        acc = acc - {1'b0, divisor};
      end
      r = acc[DUR_W-1:0];
    end
    rem_out = r;
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_particle_time_boundary_core.sv -----
// Self-checking testbench for the particle time boundary core.
`timescale 1ns / 100ps

module tb_particle_time_boundary_core
  import ptb_pkg::*;
();

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_STALL  = 300;
  localparam int SETTLE      = 20;
  localparam int RAND_PHASES = 14;
  localparam int PHASE_ITEMS = 110;
  localparam int MAX_PRINTS  = 50;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] e_val;
    logic [DATA_W-1:0] t_val;
  } particle_t;

  typedef struct packed {
    logic              lost;
    logic [DATA_W-1:0] e_out;
    logic [DATA_W-1:0] t_out;
  } boundary_res_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [2*DATA_W-1:0] s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [2*DATA_W-1:0] m_tdata;
  logic [0:0]          m_tuser;
  logic                cfg_we    = 1'b0;
  cfg_idx_t            cfg_index = CFG_MODE;
  logic [DUR_W-1:0]    cfg_wdata = '0;

  particle_t     particles_to_send[$];
  boundary_res_t predicted_results[$];

  mode_t            bc_mode_q   = BC_OPEN;
  logic [DUR_W-1:0] duration_q  = '0;
  int               err_count   = 0;
  int unsigned      cycles      = 0;
  bit               send_idle_on = 1'b0;
  bit               recv_idle_on = 1'b0;
  int               long_stall_reqs = 0;
  int               long_stall_done = 0;
  int               send_gap  = 0;
  int               recv_gap  = 0;
  int               recv_hold = 0;
  logic             item_taken = 1'b0;

  particle_time_boundary_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] clamp_q16(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (DATA_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DATA_W-1:0];
  endfunction

  function automatic boundary_res_t apply_boundary(mode_t m, logic [DUR_W-1:0] dur,
                                                   logic [DATA_W-1:0] t_raw,
                                                   logic [DATA_W-1:0] pt_raw);
    longint        t;
    longint        pt;
    longint        d;
    longint        h;
    longint        r;
    boundary_res_t res;
    t = longint'($signed(t_raw));
    pt = longint'($signed(pt_raw));
    d = longint'(dur);
    h = d >> 1;
    res.lost = 1'b0;
    case (m)
      BC_PERIODIC: begin
        if (d != 0) begin
          r = t % d;
          if (r < 0) r = r + d;
          r = (r + h) % d;
          t = r - h;
        end
      end
      BC_ABSORB: begin
        if (!(t < h && t > -h)) res.lost = 1'b1;
      end
      BC_REFLECT: begin
        if (t > h) begin
          t = d - t;
          pt = -pt;
        end else if (t < -h) begin
          t = -(d + t);
          pt = -pt;
        end
      end
      default: ;
    endcase
    res.t_out = clamp_q16(t);
    res.e_out = clamp_q16(pt);
    return res;
  endfunction

  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_time(logic [DUR_W-1:0] dur);
    longint d;
    longint h;
    longint v;
    int     delta;
    d = longint'(dur);
    h = d >> 1;
    delta = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 9))
      0: v = h + delta;
      1: v = -h + delta;
      2: v = d + delta;
      3: v = -d + delta;
      4: v = longint'(Q_MAX) - longint'($urandom_range(0, 3));
      5: v = longint'($signed(Q_MIN)) + longint'($urandom_range(0, 3));
      6, 7: begin
        v = longint'($signed($urandom));
        v = v >>> $urandom_range(0, 31);
      end
      default: v = longint'($signed($urandom));
    endcase
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    logic [DUR_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = DUR_W'($urandom_range(1, 3));
      2: v = {DUR_W{1'b1}} - DUR_W'($urandom_range(0, 1));
      3: v = 31'h0001_0000;
      4: v = DUR_W'($urandom_range(4, 16'hFFFF));
      default: begin
        v = DUR_W'($urandom);
        v = v >> $urandom_range(0, 30);
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch %s: got %h want %h, cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) bc_mode_q = mode_t'(val[MODE_W-1:0]);
    else duration_q = val;
  endtask

  task automatic set_boundary(mode_t m, logic [DUR_W-1:0] dur);
    logic [DUR_W-1:0] mode_word;
    mode_word = DUR_W'($urandom);
    mode_word[MODE_W-1:0] = m;
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_MODE, mode_word);
  endtask

  task automatic push_particle(logic [DATA_W-1:0] t, logic [DATA_W-1:0] e);
    particles_to_send.push_back('{e_val: e, t_val: t});
  endtask

  task automatic drain();
    while (particles_to_send.size() != 0 || predicted_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    boundary_res_t want;
    item_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with none expected", m_tdata[DATA_W-1:0], '0);
      end else begin
        want = predicted_results.pop_front();
        if (m_tdata[DATA_W-1:0] !== want.t_out)
          report_mismatch("time_out", m_tdata[DATA_W-1:0], want.t_out);
        if (m_tdata[2*DATA_W-1:DATA_W] !== want.e_out)
          report_mismatch("energy_out", m_tdata[2*DATA_W-1:DATA_W], want.e_out);
        if (m_tuser[0] !== want.lost)
          report_mismatch("lost", {{(DATA_W-1){1'b0}}, m_tuser[0]},
                          {{(DATA_W-1){1'b0}}, want.lost});
      end
    end
    if (!rst && s_tvalid && s_tready)
      predicted_results.push_back(apply_boundary(bc_mode_q, duration_q,
                                                 s_tdata[DATA_W-1:0],
                                                 s_tdata[2*DATA_W-1:DATA_W]));
  end

  always @(negedge clk) begin
    bit hold;
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_taken) void'(particles_to_send.pop_front());
      hold = s_tvalid && !item_taken;
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (particles_to_send.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= particles_to_send[0];
          send_gap = pick_gap(send_idle_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_stall_reqs > long_stall_done) begin
      long_stall_done++;
      recv_hold = LONG_STALL;
      m_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_gap = pick_gap(recv_idle_on);
    end
  end

  initial begin
    mode_t            m;
    logic [DUR_W-1:0] dur;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;

    // reset state: open boundary, zero duration
    push_particle('0, '0);
    push_particle(Q_MAX, Q_MIN);
    push_particle(Q_MIN, Q_MAX);
    drain();

    set_boundary(BC_PERIODIC, '0);
    push_particle(Q_MIN, 32'h0000_1234);
    push_particle(Q_MAX, Q_MIN);
    drain();

    set_boundary(BC_ABSORB, '0);
    push_particle('0, 32'h0001_0000);
    push_particle(32'h0000_0001, Q_MAX);
    drain();

    set_boundary(BC_REFLECT, '0);
    push_particle('0, Q_MIN);
    push_particle(32'h0000_0005, Q_MIN);
    push_particle(32'hFFFF_FFFB, Q_MAX);
    push_particle(Q_MIN, 32'h0000_0007);
    drain();

    set_boundary(BC_PERIODIC, 31'h0001_0000);
    push_particle(32'h0000_8000, 32'h0000_0001);
    push_particle(32'hFFFF_8000, 32'hFFFF_FFFF);
    push_particle(Q_MAX, Q_MAX);
    push_particle(Q_MIN, Q_MIN);
    drain();

    set_boundary(BC_ABSORB, 31'h0001_0000);
    push_particle(32'h0000_7FFF, 32'h0000_0002);
    push_particle(32'h0000_8000, 32'h0000_0003);
    push_particle(32'hFFFF_8000, 32'h0000_0004);
    push_particle(32'hFFFF_8001, 32'h0000_0005);
    drain();

    set_boundary(BC_REFLECT, {DUR_W{1'b1}});
    push_particle(Q_MAX, Q_MIN);
    push_particle(Q_MIN, Q_MAX);
    push_particle(32'h4000_0000, 32'h0001_0000);
    push_particle(32'hC000_0000, 32'hFFFF_0000);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      m = mode_t'($urandom_range(0, 3));
      dur = pick_duration();
      if (p < 4) m = mode_t'(p);
      if (p == 6) dur = {DUR_W{1'b1}};
      if (p == 7) dur = '0;
      set_boundary(m, dur);
      send_idle_on = (p % 3) != 1;
      recv_idle_on = (p % 3) != 2;
      if (p == 5) begin
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        long_stall_reqs++;
      end
      repeat (PHASE_ITEMS) push_particle(pick_time(dur), pick_energy());
      drain();
    end

    if (err_count == 0 && predicted_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/ptb_pkg.sv
src/ptb_rem_step.sv
src/particle_time_boundary_core.sv
tb/sv/tb_particle_time_boundary_core.sv
